### rtl/hdcd_pkg.sv
// ----------------------------------------------------------------------------
// hdcd_pkg
// Shared types, constants and mod-26 helpers for the Hill digraph crib
// decryptor.
// ----------------------------------------------------------------------------
package hdcd_pkg;

  // Letters are five-bit codes, A = 0 up to Z = 25.
  localparam int unsigned LetterW = 5;
  localparam int unsigned Modulus = 26;

  // Width of a letter times a letter in the digraph pipeline.
  localparam int unsigned ProdW = 2 * LetterW;

  // APB geometry: four 32-bit registers at byte addresses 0, 4, 8 and 12.
  localparam int unsigned NumRegs   = 4;
  localparam int unsigned DataW     = 32;
  localparam int unsigned AddrW     = $clog2(NumRegs * 4);
  localparam int unsigned RegIndexW = $clog2(NumRegs);

  // Register stages in the key derivation chain, and the settle counter width.
  localparam int unsigned KeyLatency = 4;
  localparam int unsigned SettleW    = $clog2(KeyLatency + 1);

  typedef logic [LetterW-1:0] letter_t;

  // Register indexes.
  typedef enum logic [RegIndexW-1:0] {
    RegCribFirstA  = 2'd0,
    RegCribFirstB  = 2'd1,
    RegCribSecondA = 2'd2,
    RegCribSecondB = 2'd3
  } reg_index_e;

  // Ciphertext of the two crib digraphs TH and HE.
  typedef struct packed {
    letter_t first_a;
    letter_t first_b;
    letter_t second_a;
    letter_t second_b;
  } crib_t;

  // Inverse key matrix, row-vector convention: plain = cipher * inverse.
  typedef struct packed {
    logic    invalid;
    letter_t ki0;
    letter_t ki1;
    letter_t ki2;
    letter_t ki3;
  } key_t;

  // Reduce a value below 4096 mod 26. The quotient comes from a reciprocal
  // multiply that can fall short by one, which the final compare corrects.
  function automatic letter_t mod26(input logic [11:0] v);
    logic [23:0] prod;
    logic [7:0]  quot;
    logic [11:0] rem;
    prod = {12'd0, v} * 24'd2520;
    quot = prod[23:16];
    rem  = v - 12'({4'd0, quot} * 12'd26);
    if (rem >= 12'd26) begin
      rem = rem - 12'd26;
    end
    return rem[LetterW-1:0];
  endfunction

  // Multiplicative inverse mod 26; zero where none exists.
  function automatic letter_t inv26(input letter_t v);
    letter_t r;
    case (v)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/hdcd_in_if.sv
// ----------------------------------------------------------------------------
// hdcd_in_if
// Ciphertext digraph channel: valid/ready handshake with two letters.
// ----------------------------------------------------------------------------
interface hdcd_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] cipher_first;
  logic [4:0] cipher_second;

  modport source (output valid, output cipher_first, output cipher_second, input ready);
  modport sink   (input valid, input cipher_first, input cipher_second, output ready);
endinterface

### rtl/hdcd_out_if.sv
// ----------------------------------------------------------------------------
// hdcd_out_if
// Plaintext digraph channel: valid/ready handshake with two letters and a
// flag for an unusable key.
// ----------------------------------------------------------------------------
interface hdcd_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] plain_first;
  logic [4:0] plain_second;
  logic       key_invalid;

  modport source (output valid, output plain_first, output plain_second,
                  output key_invalid, input ready);
  modport sink   (input valid, input plain_first, input plain_second,
                  input key_invalid, output ready);
endinterface

### rtl/hdcd_cfg_regs.sv
// ----------------------------------------------------------------------------
// hdcd_cfg_regs
// APB register file holding the ciphertext of the two crib digraphs.
// ----------------------------------------------------------------------------
module hdcd_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hdcd_pkg::AddrW-1:0]  paddr,
  input  logic [hdcd_pkg::DataW-1:0]  pwdata,
  output logic [hdcd_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output hdcd_pkg::crib_t             crib_o,
  output logic                        wr_o
);
  import hdcd_pkg::*;

  crib_t      crib_q, crib_d;
  reg_index_e index;
  letter_t    rd_letter;
  logic       wr;

  assign pready = 1'b1;
  assign index  = reg_index_e'(paddr[AddrW-1:2]);
  assign wr     = psel && penable && pwrite;

  // Register write decode.
  always_comb begin
    crib_d = crib_q;
    if (wr) begin
      case (index)
        RegCribFirstA:  crib_d.first_a  = pwdata[LetterW-1:0];
        RegCribFirstB:  crib_d.first_b  = pwdata[LetterW-1:0];
        RegCribSecondA: crib_d.second_a = pwdata[LetterW-1:0];
        RegCribSecondB: crib_d.second_b = pwdata[LetterW-1:0];
        default:        crib_d = crib_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crib_q <= '0;
    end else begin
      crib_q <= crib_d;
    end
  end

  // Read-back mux.
  always_comb begin
    case (index)
      RegCribFirstA:  rd_letter = crib_q.first_a;
      RegCribFirstB:  rd_letter = crib_q.first_b;
      RegCribSecondA: rd_letter = crib_q.second_a;
      RegCribSecondB: rd_letter = crib_q.second_b;
      default:        rd_letter = '0;
    endcase
  end

  assign prdata = {{(DataW - LetterW){1'b0}}, rd_letter};
  assign crib_o = crib_q;
  assign wr_o   = wr;

endmodule

### rtl/hdcd_key_derive.sv
// ----------------------------------------------------------------------------
// hdcd_key_derive
// Four-stage pipeline that turns the crib ciphertext into the inverse key.
// ----------------------------------------------------------------------------
module hdcd_key_derive (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hdcd_pkg::crib_t crib_i,
  input  logic            cfg_wr_i,
  output hdcd_pkg::key_t  key_o,
  output logic            busy_o
);
  import hdcd_pkg::*;

  letter_t                k0_q, k1_q, k2_q, k3_q;
  letter_t                bk0_q, bk1_q, bk2_q, bk3_q;
  letter_t                pa_q, pb_q;
  letter_t                ck0_q, ck1_q, ck2_q, ck3_q;
  letter_t                di_q, di_d;
  logic [LetterW:0]       det_sum;
  letter_t                det;
  key_t                   key_q, key_d;
  logic [SettleW-1:0]     settle_q, settle_d;

  // Stage A: key = inverse(crib plain) * crib cipher. The crib matrix
  // [[T,H],[H,E]] has determinant 1, so its inverse is [[4,19],[19,19]].
  always_ff @(posedge clk_i) begin
    k0_q <= mod26(12'(crib_i.first_a)  * 12'd4  + 12'(crib_i.second_a) * 12'd19);
    k1_q <= mod26(12'(crib_i.first_b)  * 12'd4  + 12'(crib_i.second_b) * 12'd19);
    k2_q <= mod26(12'(crib_i.first_a)  * 12'd19 + 12'(crib_i.second_a) * 12'd19);
    k3_q <= mod26(12'(crib_i.first_b)  * 12'd19 + 12'(crib_i.second_b) * 12'd19);
  end

  // Stage B: the two diagonal products of the determinant, reduced.
  always_ff @(posedge clk_i) begin
    pa_q  <= mod26(12'(k0_q) * 12'(k3_q));
    pb_q  <= mod26(12'(k1_q) * 12'(k2_q));
    bk0_q <= k0_q;
    bk1_q <= k1_q;
    bk2_q <= k2_q;
    bk3_q <= k3_q;
  end

  // Stage C: determinant mod 26 and its inverse.
  always_comb begin
    det_sum = (LetterW + 1)'(pa_q) + (LetterW + 1)'(Modulus) - (LetterW + 1)'(pb_q);
    if (det_sum >= (LetterW + 1)'(Modulus)) begin
      det_sum = det_sum - (LetterW + 1)'(Modulus);
    end
    det  = det_sum[LetterW-1:0];
    di_d = inv26(det);
  end

  always_ff @(posedge clk_i) begin
    di_q  <= di_d;
    ck0_q <= bk0_q;
    ck1_q <= bk1_q;
    ck2_q <= bk2_q;
    ck3_q <= bk3_q;
  end

  // Stage D: adjugate scaled by the determinant inverse.
  always_comb begin
    key_d.invalid = (di_q == '0);
    key_d.ki0     = mod26(12'(di_q) * 12'(ck3_q));
    key_d.ki1     = mod26(12'(di_q) * (12'(Modulus) - 12'(ck1_q)));
    key_d.ki2     = mod26(12'(di_q) * (12'(Modulus) - 12'(ck2_q)));
    key_d.ki3     = mod26(12'(di_q) * 12'(ck0_q));
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  // Settle counter: holds items off until the chain reflects the registers.
  always_comb begin
    settle_d = settle_q;
    if (cfg_wr_i) begin
      settle_d = SettleW'(KeyLatency);
    end else if (settle_q != '0) begin
      settle_d = settle_q - SettleW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SettleW'(KeyLatency);
    end else begin
      settle_q <= settle_d;
    end
  end

  assign key_o  = key_q;
  assign busy_o = (settle_q != '0);

endmodule

### rtl/hdcd_datapath.sv
// ----------------------------------------------------------------------------
// hdcd_datapath
// Three-stage digraph pipeline: letter reduction, products, sum and reduce.
// ----------------------------------------------------------------------------
module hdcd_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hdcd_pkg::key_t  key_i,
  input  logic            key_busy_i,
  hdcd_in_if.sink         cipher_i,
  hdcd_out_if.source      plain_o
);
  import hdcd_pkg::*;

  logic              v1_q, v2_q, v3_q;
  logic              adv1, adv2, adv3;
  letter_t           x_q, y_q, x_d, y_d;
  logic [ProdW-1:0]  p0_q, p1_q, p2_q, p3_q;
  letter_t           pf_q, ps_q;
  logic              inv_q;

  // Each stage loads when empty or when its beat moves on.
  assign adv3 = !v3_q || plain_o.ready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign cipher_i.ready = adv1 && !key_busy_i;

  // Letters 26 to 31 act as the value minus 26.
  always_comb begin
    x_d = cipher_i.cipher_first;
    y_d = cipher_i.cipher_second;
    if (x_d >= LetterW'(Modulus)) begin
      x_d = x_d - LetterW'(Modulus);
    end
    if (y_d >= LetterW'(Modulus)) begin
      y_d = y_d - LetterW'(Modulus);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= cipher_i.valid && cipher_i.ready;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Stage 1: reduced letters.
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  // Stage 2: the four products with the inverse key.
  always_ff @(posedge clk_i) begin
    if (adv2) begin
      p0_q <= ProdW'(x_q) * ProdW'(key_i.ki0);
      p1_q <= ProdW'(y_q) * ProdW'(key_i.ki2);
      p2_q <= ProdW'(x_q) * ProdW'(key_i.ki1);
      p3_q <= ProdW'(y_q) * ProdW'(key_i.ki3);
    end
  end

  // Stage 3: column sums mod 26; a singular key forces zero letters.
  always_ff @(posedge clk_i) begin
    if (adv3) begin
      inv_q <= key_i.invalid;
      if (key_i.invalid) begin
        pf_q <= '0;
        ps_q <= '0;
      end else begin
        pf_q <= mod26(12'(p0_q) + 12'(p1_q));
        ps_q <= mod26(12'(p2_q) + 12'(p3_q));
      end
    end
  end

  assign plain_o.valid        = v3_q;
  assign plain_o.plain_first  = pf_q;
  assign plain_o.plain_second = ps_q;
  assign plain_o.key_invalid  = inv_q;

endmodule

### rtl/hill_digraph_crib_decrypt_core.sv
// ----------------------------------------------------------------------------
// hill_digraph_crib_decrypt_core
// Hill 2x2 known-plaintext decryptor: derives the key from the crib
// ciphertext of TH and HE and decrypts one ciphertext digraph per beat.
// ----------------------------------------------------------------------------
// The block takes one digraph per clock cycle unless output back-pressure or
// the settling key chain holds it off; each result passes through the three
// register stages of the digraph pipeline (letter reduction, key products,
// sum and reduce mod 26). The inverse key is worked out from the four crib
// registers by a separate four-stage chain; after reset and after every
// register write the input ready stays low while that chain settles. Program the crib
// registers only while no beat is in flight. A key whose determinant has no
// inverse mod 26 yields zero letters with key_invalid set, as after reset.
module hill_digraph_crib_decrypt_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hdcd_pkg::AddrW-1:0]  paddr,
  input  logic [hdcd_pkg::DataW-1:0]  pwdata,
  output logic [hdcd_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  hdcd_in_if.sink                     cipher_i,
  hdcd_out_if.source                  plain_o
);
  import hdcd_pkg::*;

  crib_t crib;
  key_t  key;
  logic  cfg_wr;
  logic  key_busy;

  // Crib register file.
  hdcd_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .crib_o  (crib),
    .wr_o    (cfg_wr)
  );

  // Key derivation chain.
  hdcd_key_derive u_key_derive (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .crib_i   (crib),
    .cfg_wr_i (cfg_wr),
    .key_o    (key),
    .busy_o   (key_busy)
  );

  // Digraph pipeline.
  hdcd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_i      (key),
    .key_busy_i (key_busy),
    .cipher_i   (cipher_i),
    .plain_o    (plain_o)
  );

  // A singular key never lets a nonzero letter out.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plain_o.valid && plain_o.key_invalid |->
      plain_o.plain_first == '0 && plain_o.plain_second == '0)
    else $error("nonzero letters with an invalid key");

  // Output letters are always reduced.
  a_letters_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plain_o.valid |->
      plain_o.plain_first < LetterW'(Modulus) && plain_o.plain_second < LetterW'(Modulus))
    else $error("output letter not reduced mod 26");

  // No beat is taken while the key chain settles.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cipher_i.valid && cipher_i.ready |-> !key_busy)
    else $error("beat accepted while the key was settling");

  // A register write closes the input for the following cycle.
  a_write_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> !cipher_i.ready)
    else $error("input open straight after a register write");

endmodule
